FILE: hdl/assert_macros.svh
// Assertion helpers shared by the frame builder modules.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define AFB_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("frame builder assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define AFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame builder assertion failed");

`endif

FILE: hdl/afb_pkg.sv
// ----------------------------------------------------------------------------
// afb_pkg
// Shared types, character codes and helpers of the framed-stream builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package afb_pkg;

  // Control characters of the link protocol
  localparam logic [7:0] CH_ENQ  = 8'h05;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_STX  = 8'h02;
  localparam logic [7:0] CH_ETX  = 8'h03;
  localparam logic [7:0] CH_ETB  = 8'h17;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [7:0] TEXT_MAX   = 8'd239;
  localparam logic [7:0] TEXT_RESET = 8'd239;
  localparam logic [2:0] FNUM_RESET = 3'd1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DATA   = 2'd1,
    OP_END    = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  // Byte slots of one transaction's output, in emission order
  typedef enum logic [3:0] {
    SL_STX   = 4'd0,
    SL_NUM   = 4'd1,
    SL_DATA  = 4'd2,
    SL_CR1   = 4'd3,
    SL_ETX   = 4'd4,
    SL_ETB   = 4'd5,
    SL_C1    = 4'd6,
    SL_C2    = 4'd7,
    SL_CR2   = 4'd8,
    SL_LF    = 4'd9,
    SL_TAIL  = 4'd10,
    SL_START = 4'd11
  } slot_t;

  localparam int SLOT_COUNT = 11;

  // Work description handed from the front to the back
  typedef struct packed {
    logic       has_open;
    logic [7:0] num_char;
    logic       has_data;
    logic [7:0] data;
    logic       has_close;
    logic       close_final;
    logic [7:0] checksum;
    logic       has_tail;
    logic [7:0] tail_char;
  } desc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    hex_digit = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
  endfunction

endpackage

`default_nettype wire

FILE: hdl/afb_front.sv
// ----------------------------------------------------------------------------
// afb_front
// Accepts input transactions, tracks frame state, emits work descriptors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afb_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [7:0]          max_text,
  input  wire                 in_valid,
  input  wire  [1:0]          in_operation,
  input  wire  [7:0]          in_data_byte,
  input  wire                 in_record_last,
  input  wire                 q_ready,
  output logic                q_push,
  output afb_pkg::desc_t      q_desc
);

  logic [2:0] frame_number_r, frame_number_nxt;
  logic       in_frame_r, in_frame_nxt;
  logic [7:0] text_count_r, text_count_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;

  logic        fire;
  logic [7:0]  limit;
  logic [7:0]  num_char;
  logic [7:0]  sum_data;
  logic [7:0]  count_inc;
  logic [7:0]  sum_final;
  afb_pkg::op_t op;

  assign op       = afb_pkg::op_t'(in_operation);
  assign fire     = in_valid && q_ready;
  assign num_char = afb_pkg::CH_ZERO + {5'd0, frame_number_r};
  // Clamp the register into 1..239
  assign limit    = (max_text == 8'd0) ? 8'd1 :
                    (max_text > afb_pkg::TEXT_MAX) ? afb_pkg::TEXT_MAX : max_text;
  assign sum_data  = (in_frame_r ? running_sum_r : num_char) + in_data_byte;
  assign count_inc = (in_frame_r ? text_count_r : 8'd0) + 8'd1;
  // Checksum of an open frame closed as a record end
  assign sum_final = running_sum_r + afb_pkg::CH_CR + afb_pkg::CH_ETX;

  always_comb begin
    frame_number_nxt = frame_number_r;
    in_frame_nxt     = in_frame_r;
    text_count_nxt   = text_count_r;
    running_sum_nxt  = running_sum_r;
    q_push           = 1'b0;
    q_desc           = '0;
    if (fire) begin
      unique case (op)
        afb_pkg::OP_START, afb_pkg::OP_END: begin
          q_push               = 1'b1;
          q_desc.has_close     = in_frame_r;
          q_desc.close_final   = 1'b1;
          q_desc.checksum      = sum_final;
          q_desc.has_tail      = 1'b1;
          q_desc.tail_char     = (op == afb_pkg::OP_START) ? afb_pkg::CH_ENQ
                                                           : afb_pkg::CH_EOT;
          in_frame_nxt         = 1'b0;
          text_count_nxt       = 8'd0;
          running_sum_nxt      = 8'd0;
          if (op == afb_pkg::OP_START) begin
            frame_number_nxt = afb_pkg::FNUM_RESET;
          end else if (in_frame_r) begin
            frame_number_nxt = frame_number_r + 3'd1;
          end
        end
        afb_pkg::OP_DATA: begin
          q_push          = 1'b1;
          q_desc.has_open = !in_frame_r;
          q_desc.num_char = num_char;
          q_desc.has_data = 1'b1;
          q_desc.data     = in_data_byte;
          if (in_record_last) begin
            q_desc.has_close   = 1'b1;
            q_desc.close_final = 1'b1;
            q_desc.checksum    = sum_data + afb_pkg::CH_CR + afb_pkg::CH_ETX;
          end else if (count_inc >= limit) begin
            q_desc.has_close   = 1'b1;
            q_desc.close_final = 1'b0;
            q_desc.checksum    = sum_data + afb_pkg::CH_ETB;
          end
          if (q_desc.has_close) begin
            in_frame_nxt     = 1'b0;
            text_count_nxt   = 8'd0;
            running_sum_nxt  = 8'd0;
            frame_number_nxt = frame_number_r + 3'd1;
          end else begin
            in_frame_nxt    = 1'b1;
            text_count_nxt  = count_inc;
            running_sum_nxt = sum_data;
          end
        end
        afb_pkg::OP_UNUSED: begin
          // drop: no output, state unchanged
          q_push = 1'b0;
        end
        default: q_push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_number_r <= afb_pkg::FNUM_RESET;
      in_frame_r     <= 1'b0;
      text_count_r   <= 8'd0;
      running_sum_r  <= 8'd0;
    end else begin
      frame_number_r <= frame_number_nxt;
      in_frame_r     <= in_frame_nxt;
      text_count_r   <= text_count_nxt;
      running_sum_r  <= running_sum_nxt;
    end
  end

`include "assert_macros.svh"

  `AFB_ASSERT_NEXT(a_close_clears_frame, q_push && q_desc.has_close, !in_frame_r && (text_count_r == 8'd0) && (running_sum_r == 8'd0))
  `AFB_ASSERT(a_open_only_when_idle, !(q_push && q_desc.has_open && in_frame_r))

endmodule

`default_nettype wire

FILE: hdl/afb_queue.sv
// ----------------------------------------------------------------------------
// afb_queue
// Small descriptor FIFO decoupling the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afb_queue #(
  parameter int DEPTH = afb_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  afb_pkg::desc_t      push_desc,
  output logic                push_ready,
  input  wire                 pop,
  output logic                head_valid,
  output afb_pkg::desc_t      head_desc
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  afb_pkg::desc_t slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_desc  = slots_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_desc;
    end
  end

`include "assert_macros.svh"

  `AFB_ASSERT(a_count_in_range, count_r <= CNT_FULL)

endmodule

`default_nettype wire

FILE: hdl/afb_back.sv
// ----------------------------------------------------------------------------
// afb_back
// Walks the byte slots of each descriptor into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afb_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 head_valid,
  input  afb_pkg::desc_t      head_desc,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  localparam int SW = 4;

  afb_pkg::slot_t slot_r, slot_nxt;
  afb_pkg::slot_t eff_slot;
  afb_pkg::slot_t next_slot;

  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_byte_r, out_byte_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [afb_pkg::SLOT_COUNT-1:0] en;
  logic [afb_pkg::SLOT_COUNT-1:0] from_cur;
  logic [afb_pkg::SLOT_COUNT-1:0] after_eff;
  logic                          has_next;
  logic                          load;
  logic [7:0]                    slot_byte;

  // Lowest set bit of a slot mask
  function automatic logic [SW-1:0] lowest(input logic [afb_pkg::SLOT_COUNT-1:0] v);
    logic [SW-1:0] idx;
    idx = '0;
    for (int i = afb_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SW'(i);
      end
    end
    return idx;
  endfunction

  always_comb begin
    en = '0;
    en[afb_pkg::SL_STX]  = head_desc.has_open;
    en[afb_pkg::SL_NUM]  = head_desc.has_open;
    en[afb_pkg::SL_DATA] = head_desc.has_data;
    en[afb_pkg::SL_CR1]  = head_desc.has_close && head_desc.close_final;
    en[afb_pkg::SL_ETX]  = head_desc.has_close && head_desc.close_final;
    en[afb_pkg::SL_ETB]  = head_desc.has_close && !head_desc.close_final;
    en[afb_pkg::SL_C1]   = head_desc.has_close;
    en[afb_pkg::SL_C2]   = head_desc.has_close;
    en[afb_pkg::SL_CR2]  = head_desc.has_close;
    en[afb_pkg::SL_LF]   = head_desc.has_close;
    en[afb_pkg::SL_TAIL] = head_desc.has_tail;
    for (int i = 0; i < afb_pkg::SLOT_COUNT; i++) begin
      from_cur[i]  = (slot_r == afb_pkg::SL_START) || (SW'(i) >= slot_r);
      after_eff[i] = en[i] && (SW'(i) > eff_slot);
    end
  end

  assign eff_slot  = afb_pkg::slot_t'(lowest(en & from_cur));
  assign has_next  = (after_eff != '0);
  assign next_slot = afb_pkg::slot_t'(lowest(after_eff));
  assign load      = head_valid && (!out_valid_r || out_ready);
  assign pop       = load && !has_next;

  // Next state of the slot sequencer
  always_comb begin
    slot_nxt = slot_r;
    if (load) begin
      slot_nxt = has_next ? next_slot : afb_pkg::SL_START;
    end
  end

  // Byte for the current slot
  always_comb begin
    unique case (eff_slot) inside
      afb_pkg::SL_STX:                  slot_byte = afb_pkg::CH_STX;
      afb_pkg::SL_NUM:                  slot_byte = head_desc.num_char;
      afb_pkg::SL_DATA:                 slot_byte = head_desc.data;
      afb_pkg::SL_CR1, afb_pkg::SL_CR2: slot_byte = afb_pkg::CH_CR;
      afb_pkg::SL_ETX:                  slot_byte = afb_pkg::CH_ETX;
      afb_pkg::SL_ETB:                  slot_byte = afb_pkg::CH_ETB;
      afb_pkg::SL_C1:  slot_byte = afb_pkg::hex_digit(head_desc.checksum[7:4]);
      afb_pkg::SL_C2:  slot_byte = afb_pkg::hex_digit(head_desc.checksum[3:0]);
      afb_pkg::SL_LF:                   slot_byte = afb_pkg::CH_LF;
      afb_pkg::SL_TAIL:                 slot_byte = head_desc.tail_char;
      default:                          slot_byte = 8'h00;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = slot_byte;
      out_last_nxt  = !has_next;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= afb_pkg::SL_START;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`include "assert_macros.svh"

  `AFB_ASSERT(a_mid_desc_has_head, (slot_r == afb_pkg::SL_START) || head_valid)
  `AFB_ASSERT(a_desc_not_empty, !head_valid || (en != '0))

endmodule

`default_nettype wire

FILE: hdl/astm_frame_builder_top.sv
// ----------------------------------------------------------------------------
// astm_frame_builder_top
// Framed-stream builder for a laboratory link session (E1381 style framing).
// ----------------------------------------------------------------------------
// Each input transaction is a session start, a record text byte or a session
// end; the block returns the framed byte stream, one output transaction per
// byte, with out_last marking the final byte caused by an input. A start gives
// ENQ and resets the frame number to 1, an end gives EOT, and either one first
// closes an open frame as a record end. Text bytes are wrapped into frames of
// STX, frame digit (1..7 then 0), text, then CR ETX or ETB, two upper-case hex
// checksum characters, CR LF. cfg_wdata written with cfg_we sets the most text
// bytes per frame (reset 239; 0 acts as 1, above 239 acts as 239); write it
// only while the block is idle. The front stage takes one input per cycle as
// long as its descriptor queue (QUEUE_DEPTH entries) has room; the back stage
// sends one output byte per cycle while out_ready is high and a descriptor
// waits. An input gives 1 to 9 bytes: 1 for a text byte inside a frame, 3 to
// open one, up to 9 to open, fill and close one; output limits steady state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module astm_frame_builder_top #(
  parameter int QUEUE_DEPTH = afb_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  // configuration
  input  wire         cfg_we,
  input  wire  [7:0]  cfg_wdata,
  // input channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_operation,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_record_last,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic [7:0]     max_text_r, max_text_nxt;
  logic           q_push;
  logic           q_ready;
  afb_pkg::desc_t q_desc;
  logic           head_valid;
  afb_pkg::desc_t head_desc;
  logic           pop;

  // Frame size limit; user writes it only while idle, the block does not check
  assign max_text_nxt = cfg_we ? cfg_wdata : max_text_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_text_r <= afb_pkg::TEXT_RESET;
    end else begin
      max_text_r <= max_text_nxt;
    end
  end

  // Accept a transaction whenever the queue can take its descriptor
  assign in_ready = q_ready;

  // Front: classify the transaction and update frame state
  afb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .max_text       (max_text_r),
    .in_valid       (in_valid),
    .in_operation   (in_operation),
    .in_data_byte   (in_data_byte),
    .in_record_last (in_record_last),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_desc         (q_desc)
  );

  // Queue: let front and back stall independently
  afb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_desc),
    .push_ready (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  // Back: emit the bytes of each descriptor, one per cycle while out_ready allows
  afb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire
